// ----- hw/rtl/i2c_edid_block_reader_unit_assert.svh -----
// Assertion macros for the I2C EDID block reader.
// Used by i2c_edid_block_reader_unit; expects clk_i and rst_ni in scope.
`ifndef I2C_EDID_BLOCK_READER_UNIT_ASSERT_SVH
`define I2C_EDID_BLOCK_READER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Check an implication property on every clock edge outside reset.
`define EDID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("edid reader assertion failed");
// Check that a condition never holds outside reset.
`define EDID_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("edid reader forbidden condition seen");
`else
`define EDID_ASSERT(lbl, prop)
`define EDID_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- hw/rtl/edid_rd_pkg.sv -----
// Package for the I2C EDID block reader: sequencer step codes, line bits,
// register map and block size. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package edid_rd_pkg;

  localparam int unsigned BlockBytes = 256;
  localparam logic [7:0]  LastIndex  = 8'(BlockBytes - 1);

  // Register map: register index is paddr[2]
  localparam int unsigned AddrWidth      = 3;
  localparam logic        RegDevAddr     = 1'b0;
  localparam logic        RegStartOffset = 1'b1;

  localparam logic [6:0] DevAddrReset = 7'd80;

  // Line state bits
  localparam int unsigned LnScl = 0;
  localparam int unsigned LnOe  = 1;
  localparam int unsigned LnOut = 2;

  localparam logic [2:0] LineScl = 3'b001;
  localparam logic [2:0] LineOe  = 3'b010;
  localparam logic [2:0] LineOut = 3'b100;

  // Failure stage codes
  localparam logic [1:0] FailWaddr = 2'd0;
  localparam logic [1:0] FailWoff  = 2'd1;
  localparam logic [1:0] FailRaddr = 2'd2;

  typedef enum logic [3:0] {
    StIdle     = 4'd0,
    StStart1   = 4'd1,
    StWaddr    = 4'd2,
    StWaddrAck = 4'd3,
    StWoff     = 4'd4,
    StWoffAck  = 4'd5,
    StStart2   = 4'd6,
    StRaddr    = 4'd7,
    StRaddrAck = 4'd8,
    StRbits    = 4'd9,
    StRack     = 4'd10,
    StStop     = 4'd11
  } step_e;

endpackage

`default_nettype wire

// ----- hw/rtl/i2c_edid_block_reader_unit.sv -----
// I2C EDID block reader: bit-banged I2C master sequencer, one phase per tick.
// Depends on edid_rd_pkg and i2c_edid_block_reader_unit_assert.svh.
//
// Usage: each transfer on the input channel (in_valid_i/in_ready_o) is one
// phase tick of the bus timebase and carries start_req_i and the sampled
// SDA level. Each tick yields exactly one result transfer on the output
// channel (out_valid_o/out_ready_i): SCL/SDA line controls, an optional
// received byte with its index, busy, done and failure flags.
// A tick's result is registered at the accept edge and shows from the
// next cycle. Throughput is one tick per cycle while out_ready_i is high;
// the sequencer state and the output register update together at the
// accept edge, so the single combinational step between them sets the rate.
// A result waiting in the output register does not block the next tick
// when out_ready_i is high in the same cycle; while the receiver stalls,
// the held result stays and no new tick is taken.
// Reset puts the sequencer in idle with all lines released and SCL low, the
// bus marked not started, device_address 80 and start_offset 0. The APB
// port (pready always high) writes registers at byte addresses 0 and 4.
`timescale 1ns / 1ps
`default_nettype none

module i2c_edid_block_reader_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // APB configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [edid_rd_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  // Tick input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                start_req_i,
  input  wire logic                                sda_in_i,
  // Result output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     scl_high_o,
  output logic                                     sda_drive_o,
  output logic                                     sda_level_o,
  output logic                                     byte_valid_o,
  output logic [7:0]                               byte_value_o,
  output logic [7:0]                               byte_index_o,
  output logic                                     last_byte_o,
  output logic                                     busy_res_o,
  output logic                                     done_ok_o,
  output logic                                     failed_o,
  output logic [1:0]                               fail_stage_o
);

  import edid_rd_pkg::*;

  `include "i2c_edid_block_reader_unit_assert.svh"

  // Configuration registers
  logic [6:0] dev_addr_q;
  logic [7:0] start_off_q;
  logic       cfg_wr;

  // Sequencer state
  step_e      step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] bytes_q, bytes_d;
  logic       started_q, started_d;
  logic [2:0] line_q, line_d;

  // Output register
  logic       out_valid_q;
  logic [2:0] line_out_q;
  logic       bv_q, blast_q, busy_q, done_q, fail_q;
  logic [7:0] bval_q, bidx_q;
  logic [1:0] fstage_q;

  // Combinational results of one tick
  step_e      cur;
  logic [1:0] ph;
  logic [7:0] wr_val;
  logic       wr_bit;
  logic       is_last;
  logic       bv, blast, done, fail;
  logic [7:0] bval, bidx;
  logic [1:0] fstage;
  logic       in_acc;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (paddr[2])
      RegDevAddr:     prdata = {25'd0, dev_addr_q};
      RegStartOffset: prdata = {24'd0, start_off_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrReset;
      start_off_q <= 8'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegDevAddr) begin
        dev_addr_q <= pwdata[6:0];
      end else begin
        start_off_q <= pwdata[7:0];
      end
    end
  end

  assign is_last = (bytes_q == LastIndex);

  // Write states are only ever entered from the registered step
  always_comb begin
    unique case (step_q)
      StWaddr: wr_val = {dev_addr_q, 1'b0};
      StWoff:  wr_val = start_off_q;
      default: wr_val = {dev_addr_q, 1'b1};
    endcase
  end
  assign wr_bit = wr_val[3'd7 - bit_q];

  always_comb begin
    step_d    = step_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    bytes_d   = bytes_q;
    started_d = started_q;
    line_d    = line_q;
    bv        = 1'b0;
    bval      = 8'd0;
    bidx      = 8'd0;
    blast     = 1'b0;
    done      = 1'b0;
    fail      = 1'b0;
    fstage    = FailWaddr;
    cur       = step_q;
    ph        = phase_q;

    // A request from idle runs a start phase in the same tick: phase 0 if started, else phase 2
    if (step_q == StIdle && start_req_i) begin
      cur     = StStart1;
      ph      = started_q ? 2'd0 : 2'd2;
      step_d  = StStart1;
    end

    unique case (cur)
      StIdle: begin
      end
      StStart1, StStart2: begin
        unique case (ph)
          2'd0:    line_d = LineOe | LineOut;
          2'd1:    line_d = LineOe | LineOut | LineScl;
          2'd2:    line_d = LineOe | LineScl;
          default: line_d = LineOe;
        endcase
        if (ph == 2'd3) begin
          started_d = 1'b1;
          phase_d   = 2'd0;
          bit_d     = 3'd0;
          step_d    = (cur == StStart1) ? StWaddr : StRaddr;
        end else begin
          phase_d = ph + 2'd1;
        end
      end
      StWaddr, StWoff, StRaddr: begin
        priority if (ph == 2'd0) begin
          line_d = wr_bit ? (LineOe | LineOut) : LineOe;
        end else if (ph == 2'd1) begin
          line_d = line_q | LineScl;
        end else begin
          line_d = line_q & ~LineScl;
        end
        if (ph >= 2'd2) begin
          phase_d = 2'd0;
          bit_d   = bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            unique case (cur)
              StWaddr: step_d = StWaddrAck;
              StWoff:  step_d = StWoffAck;
              default: step_d = StRaddrAck;
            endcase
          end
        end else begin
          phase_d = ph + 2'd1;
        end
      end
      StWaddrAck, StWoffAck, StRaddrAck: begin
        line_d = (ph == 2'd1) ? LineScl : 3'b000;
        if (ph >= 2'd2) begin
          phase_d = 2'd0;
          if (sda_in_i) begin
            // Missing ACK: go idle, leave lines and started flag as they are
            fail   = 1'b1;
            step_d = StIdle;
            unique case (cur)
              StWaddrAck: fstage = FailWaddr;
              StWoffAck:  fstage = FailWoff;
              default:    fstage = FailRaddr;
            endcase
          end else begin
            unique case (cur)
              StWaddrAck: step_d = StWoff;
              StWoffAck:  step_d = StStart2;
              default: begin
                step_d  = StRbits;
                bytes_d = 8'd0;
                bit_d   = 3'd0;
              end
            endcase
          end
        end else begin
          phase_d = ph + 2'd1;
        end
      end
      StRbits: begin
        line_d = (ph == 2'd1) ? LineScl : 3'b000;
        if (ph >= 2'd2) begin
          phase_d = 2'd0;
          shift_d = {shift_q[6:0], sda_in_i};
          bit_d   = bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            step_d = StRack;
          end
        end else begin
          phase_d = ph + 2'd1;
        end
      end
      StRack: begin
        // ACK every byte but the last, which is NACKed
        priority if (ph == 2'd0) begin
          line_d = is_last ? (LineOe | LineOut) : LineOe;
        end else if (ph == 2'd1) begin
          line_d = line_q | LineScl;
        end else begin
          line_d = line_q & ~LineScl;
        end
        if (ph >= 2'd2) begin
          phase_d = 2'd0;
          bv      = 1'b1;
          bval    = shift_q;
          bidx    = bytes_q;
          blast   = is_last;
          bytes_d = bytes_q + 8'd1;
          step_d  = is_last ? StStop : StRbits;
        end else begin
          phase_d = ph + 2'd1;
        end
      end
      StStop: begin
        unique case (ph)
          2'd0:    line_d = LineOe;
          2'd1:    line_d = LineOe | LineScl;
          default: line_d = LineScl;
        endcase
        if (ph >= 2'd2) begin
          phase_d   = 2'd0;
          started_d = 1'b0;
          done      = 1'b1;
          step_d    = StIdle;
        end else begin
          phase_d = ph + 2'd1;
        end
      end
      default: begin
        step_d  = StIdle;
        phase_d = 2'd0;
        bit_d   = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StIdle;
      phase_q     <= 2'd0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      bytes_q     <= 8'd0;
      started_q   <= 1'b0;
      line_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        step_q    <= step_d;
        phase_q   <= phase_d;
        bit_q     <= bit_d;
        shift_q   <= shift_d;
        bytes_q   <= bytes_d;
        started_q <= started_d;
        line_q    <= line_d;
      end
      // Hold a result until its transfer; refill on every accepted tick
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_out_q <= line_d;
      bv_q       <= bv;
      bval_q     <= bval;
      bidx_q     <= bidx;
      blast_q    <= blast;
      busy_q     <= (step_d != StIdle);
      done_q     <= done;
      fail_q     <= fail;
      fstage_q   <= fstage;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_high_o   = line_out_q[LnScl];
  assign sda_drive_o  = line_out_q[LnOe];
  assign sda_level_o  = line_out_q[LnOut];
  assign byte_valid_o = bv_q;
  assign byte_value_o = bval_q;
  assign byte_index_o = bidx_q;
  assign last_byte_o  = blast_q;
  assign busy_res_o   = busy_q;
  assign done_ok_o    = done_q;
  assign failed_o     = fail_q;
  assign fail_stage_o = fstage_q;

  // The last byte hands over to the stop sequence
  `EDID_ASSERT(a_last_then_busy, out_valid_q && bv_q && blast_q |-> busy_q)
  // A completed stop leaves SCL high, SDA released and the sequencer idle
  `EDID_ASSERT(a_done_lines, out_valid_q && done_q |-> !busy_q && line_out_q == LineScl)
  // A failure ends the sequence and never coincides with a byte or a stop
  `EDID_ASSERT(a_fail_idle, out_valid_q && fail_q |-> !busy_q && !bv_q && !done_q)
  // A held result is never overwritten
  `EDID_ASSERT_NEVER(a_no_overwrite, in_acc && out_valid_q && !out_ready_i)

endmodule

`default_nettype wire
